@@ sv/spsi_pkg.sv @@
// Shared types and constants for the seismic packet segment indexer.
// No dependencies; imported by every module of the block.
`default_nettype none
package spsi_pkg;

    localparam int MUL_X_W = 64;
    localparam int MUL_Y_W = 48;
    localparam int MUL_P_W = MUL_X_W + MUL_Y_W;
    localparam int NSP_W   = 70;   // 40-bit count times 1e9
    localparam int CMP_W   = 128;

    localparam int DEF_RATE_FRAC_BITS = 16;
    localparam int DEF_OFFSET_WIDTH   = 48;

    localparam logic [MUL_Y_W-1:0] NS_PER_S = 48'd1000000000;
    localparam logic [63:0] SIGN64 = 64'h8000_0000_0000_0000;
    localparam logic [63:0] MAXPOS = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [39:0] CNT_MAX = 40'hFF_FFFF_FFFF;

    localparam logic [1:0] ACT_RECORD   = 2'd0;
    localparam logic [1:0] ACT_END      = 2'd1;
    localparam logic [1:0] ACT_ERROR    = 2'd2;
    localparam logic [1:0] ACT_RESERVED = 2'd3;

    localparam logic [1:0] KIND_BREAK = 2'd0;
    localparam logic [1:0] KIND_EMPTY = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_TA_GO,
        ST_TA_WAIT,
        ST_TB_GO,
        ST_TB_WAIT,
        ST_TCMP,
        ST_E_START,
        ST_E_MUL_WAIT,
        ST_E_DIV_GO,
        ST_E_DIV_WAIT,
        ST_E_SAT,
        ST_OUT,
        ST_UPD
    } state_t;

endpackage
`default_nettype wire

@@ sv/spsi_mul.sv @@
// Shared shift-add multiplier, one multiplier bit per cycle.
// Depends on spsi_pkg for operand widths.
`default_nettype none
module spsi_mul
    import spsi_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic [MUL_X_W-1:0] x,
    input  wire logic [MUL_Y_W-1:0] y,
    output logic                    done,
    output logic [MUL_P_W-1:0]      p
);

    localparam int CNT_W = $clog2(MUL_Y_W);

    logic [MUL_P_W-1:0] mcand_reg;
    logic [MUL_Y_W-1:0] mplier_reg;
    logic [MUL_P_W-1:0] acc_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               busy_reg;
    logic               done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(MUL_Y_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mcand_reg  <= MUL_P_W'(x);
            mplier_reg <= y;
            acc_reg    <= '0;
        end
        else if (busy_reg)
        begin
            if (mplier_reg[0])
                acc_reg <= acc_reg + mcand_reg;
            mcand_reg  <= {mcand_reg[MUL_P_W-2:0], 1'b0};
            mplier_reg <= {1'b0, mplier_reg[MUL_Y_W-1:1]};
        end
    end

    assign done = done_reg;
    assign p    = acc_reg;

endmodule
`default_nettype wire

@@ sv/spsi_div.sv @@
// Restoring divider, one quotient bit per cycle, 48-bit divisor.
// Depends on spsi_pkg for the divisor width.
`default_nettype none
module spsi_div
    import spsi_pkg::*;
#(
    parameter int NUM_W = NSP_W + DEF_RATE_FRAC_BITS
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic [NUM_W-1:0]   num,
    input  wire logic [MUL_Y_W-1:0] den,
    output logic                    done,
    output logic [NUM_W-1:0]        q
);

    localparam int CNT_W = $clog2(NUM_W);

    logic [NUM_W-1:0]   num_reg;   // numerator shifts out, quotient shifts in
    logic [MUL_Y_W-1:0] rem_reg;
    logic [MUL_Y_W-1:0] den_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               busy_reg;
    logic               done_reg;
    logic [MUL_Y_W:0]   sh;
    logic [MUL_Y_W:0]   diff;
    logic               qbit;

    always_comb
    begin
        sh   = {rem_reg, num_reg[NUM_W-1]};
        diff = sh - {1'b0, den_reg};
        qbit = (sh >= {1'b0, den_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(NUM_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            rem_reg <= qbit ? diff[MUL_Y_W-1:0] : sh[MUL_Y_W-1:0];
            num_reg <= {num_reg[NUM_W-2:0], qbit};
        end
    end

    assign done = done_reg;
    assign q    = num_reg;

endmodule
`default_nettype wire

@@ sv/seismic_packet_segment_indexer.sv @@
// Seismic packet segment indexer: top level with sequencer and segment state.
// Uses spsi_pkg, spsi_mul (shared multiplier) and spsi_div (divider).
//
// Usage: record header requests come in on in_valid/in_stall; one request
// is taken at a time and in_stall stays high until its work is done.
// Index entries leave on out_valid/out_stall from an output register, so a
// finished entry may wait while the next request is taken.
// Work per request: a record that starts a segment, or joins one with tear
// checking off, needs only the decide and update states; a joining record with
// tear checking on also runs two tear tests, each with two waits on the shared
// multiplier; a tear found by the first test skips the second. A request that
// closes a segment also computes the end time (skipped at zero rate): one
// multiplier pass then one bit-per-cycle divider pass, plus any output stall.
// An entry waiting in the output register only holds up a request that
// itself produces an entry.
// The one config register (split_on_time_tears) is written on
// cfg_valid/cfg_ready, with cfg_ready always high; write it only when idle.
// Reset clears the open segment and sets split_on_time_tears to 1.
`default_nettype none
module seismic_packet_segment_indexer
    import spsi_pkg::*;
#(
    parameter int RATE_FRAC_BITS = DEF_RATE_FRAC_BITS,
    parameter int OFFSET_WIDTH   = DEF_OFFSET_WIDTH
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  action,
    input  wire logic        id_valid,
    input  wire logic [63:0] source_tag,
    input  wire logic [63:0] start_ns,
    input  wire logic [47:0] rate_fixed,
    input  wire logic [30:0] record_samples,
    input  wire logic [47:0] record_offset,
    input  wire logic [23:0] record_bytes,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [1:0]       entry_kind,
    output logic             offset_gap,
    output logic [63:0]      seg_tag,
    output logic [47:0]      seg_offset,
    output logic [47:0]      seg_bytes,
    output logic [63:0]      seg_start_ns,
    output logic [63:0]      seg_end_ns,
    output logic [63:0]      tail_start_ns,
    output logic [47:0]      seg_rate,
    output logic [39:0]      seg_samples
);

    localparam int NUM_W = NSP_W + RATE_FRAC_BITS;
    localparam logic [47:0] OFF_MASK = (OFFSET_WIDTH >= 48) ? 48'hFFFF_FFFF_FFFF :
                                       48'((64'd1 << OFFSET_WIDTH) - 64'd1);
    localparam logic [CMP_W-1:0] TEAR_LIM = CMP_W'(NS_PER_S) << (RATE_FRAC_BITS - 1);

    state_t state_reg, state_next;

    logic split_reg;

    // latched request
    logic [1:0]  act_reg;
    logic        idv_reg;
    logic [63:0] tag_in_reg;
    logic [63:0] start_in_reg;
    logic [47:0] rate_in_reg;
    logic [30:0] samp_in_reg;
    logic [47:0] off_in_reg;
    logic [23:0] bytes_in_reg;

    // segment state
    logic        open_reg;
    logic [63:0] cur_tag_reg;
    logic [47:0] cur_offset_reg;
    logic [47:0] prev_end_reg;
    logic [63:0] cur_start_reg;
    logic [63:0] prev_start_reg;
    logic [47:0] prev_rate_reg;
    logic [30:0] prev_samp_reg;
    logic [39:0] cur_samp_reg;

    // work registers
    logic               brk_reg;
    logic               gap_reg;
    logic [1:0]         kind_reg;
    logic               zero_res_reg;
    logic               tsel_reg;
    logic               neg_reg;
    logic [MUL_P_W-1:0] a_reg;
    logic [63:0]        end_reg;
    logic               out_valid_reg;

    logic               mul_go;
    logic [MUL_X_W-1:0] mul_x;
    logic [MUL_Y_W-1:0] mul_y;
    logic               mul_done;
    logic [MUL_P_W-1:0] mul_p;
    logic               div_go;
    logic               div_done;
    logic [NUM_W-1:0]   div_q;

    logic        is_flush;
    logic        tag_chg;
    logic        rate_chg;
    logic        gap;
    logic [63:0] tref;
    logic [39:0] tn;
    logic        tneg;
    logic [63:0] tmag;
    logic [39:0] n_end;
    logic [CMP_W-1:0] ta;
    logic [CMP_W-1:0] tb;
    logic [CMP_W-1:0] terr;
    logic        tear;
    logic        slot_free;
    logic [63:0] room;
    logic [63:0] end_sat;
    logic [40:0] samp_sum;

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != ST_IDLE);
    assign slot_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        is_flush = (act_reg == ACT_END) || (act_reg == ACT_ERROR);
        tag_chg  = (tag_in_reg != cur_tag_reg);
        rate_chg = (rate_in_reg != prev_rate_reg);
        gap      = (off_in_reg != prev_end_reg);

        tref = tsel_reg ? cur_start_reg : prev_start_reg;
        tn   = tsel_reg ? cur_samp_reg : 40'(prev_samp_reg);
        tneg = $signed(start_in_reg) < $signed(tref);
        tmag = tneg ? (tref - start_in_reg) : (start_in_reg - tref);

        ta = CMP_W'(a_reg);
        tb = CMP_W'(mul_p[NSP_W-1:0]) << RATE_FRAC_BITS;
        if (neg_reg)
            terr = ta + tb;
        else if (ta >= tb)
            terr = ta - tb;
        else
            terr = tb - ta;
        tear = (terr > TEAR_LIM);

        n_end = (cur_samp_reg == 40'd0) ? 40'd1 : (cur_samp_reg - 40'd1);

        if (cur_samp_reg == 40'd0)
        begin
            room = cur_start_reg - SIGN64;
            end_sat = (div_q > NUM_W'(room)) ? SIGN64 : (cur_start_reg - div_q[63:0]);
        end
        else
        begin
            room = MAXPOS - cur_start_reg;
            end_sat = (div_q > NUM_W'(room)) ? MAXPOS : (cur_start_reg + div_q[63:0]);
        end

        samp_sum = {1'b0, cur_samp_reg} + 41'(samp_in_reg);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (in_valid)
                    state_next = ST_DECIDE;
            ST_DECIDE:
                if (is_flush)
                begin
                    if (open_reg)
                        state_next = ST_E_START;
                    else if (act_reg == ACT_END)
                        state_next = ST_OUT;
                    else
                        state_next = ST_UPD;
                end
                else if (act_reg != ACT_RECORD || !idv_reg)
                    state_next = ST_IDLE;
                else if (!open_reg)
                    state_next = ST_UPD;
                else if (split_reg && !tag_chg && !rate_chg)
                    state_next = ST_TA_GO;
                else if (tag_chg || rate_chg || gap)
                    state_next = ST_E_START;
                else
                    state_next = ST_UPD;
            ST_TA_GO:
                state_next = ST_TA_WAIT;
            ST_TA_WAIT:
                if (mul_done)
                    state_next = ST_TB_GO;
            ST_TB_GO:
                state_next = ST_TB_WAIT;
            ST_TB_WAIT:
                if (mul_done)
                    state_next = ST_TCMP;
            ST_TCMP:
                if (tear)
                    state_next = ST_E_START;
                else if (!tsel_reg)
                    state_next = ST_TA_GO;
                else if (gap_reg)
                    state_next = ST_E_START;
                else
                    state_next = ST_UPD;
            ST_E_START:
                if (prev_rate_reg == 48'd0)
                    state_next = ST_OUT;
                else
                    state_next = ST_E_MUL_WAIT;
            ST_E_MUL_WAIT:
                if (mul_done)
                    state_next = ST_E_DIV_GO;
            ST_E_DIV_GO:
                state_next = ST_E_DIV_WAIT;
            ST_E_DIV_WAIT:
                if (div_done)
                    state_next = ST_E_SAT;
            ST_E_SAT:
                state_next = ST_OUT;
            ST_OUT:
                if (slot_free)
                    state_next = ST_UPD;
            ST_UPD:
                state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // unit launch and operands
    always_comb
    begin
        mul_go = 1'b0;
        mul_x  = '0;
        mul_y  = NS_PER_S;
        div_go = 1'b0;
        case (state_reg)
            ST_TA_GO:
            begin
                mul_go = 1'b1;
                mul_x  = tmag;
                mul_y  = prev_rate_reg;
            end
            ST_TB_GO:
            begin
                mul_go = 1'b1;
                mul_x  = MUL_X_W'(tn);
            end
            ST_E_START:
            begin
                mul_go = (prev_rate_reg != 48'd0);
                mul_x  = MUL_X_W'(n_end);
            end
            ST_E_DIV_GO:
                div_go = 1'b1;
            default:
                mul_go = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            split_reg     <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
                split_reg <= cfg_data;
            if (state_reg == ST_OUT && slot_free)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // segment state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg       <= 1'b0;
            cur_tag_reg    <= '0;
            cur_offset_reg <= '0;
            prev_end_reg   <= '0;
            cur_start_reg  <= '0;
            prev_start_reg <= '0;
            prev_rate_reg  <= '0;
            prev_samp_reg  <= '0;
            cur_samp_reg   <= '0;
        end
        else if (state_reg == ST_UPD)
        begin
            if (is_flush)
            begin
                open_reg       <= 1'b0;
                cur_tag_reg    <= '0;
                cur_offset_reg <= '0;
                prev_end_reg   <= '0;
                cur_start_reg  <= '0;
                prev_start_reg <= '0;
                prev_rate_reg  <= '0;
                prev_samp_reg  <= '0;
                cur_samp_reg   <= '0;
            end
            else
            begin
                prev_start_reg <= start_in_reg;
                prev_rate_reg  <= rate_in_reg;
                prev_samp_reg  <= samp_in_reg;
                prev_end_reg   <= (off_in_reg + 48'(bytes_in_reg)) & OFF_MASK;
                if (!open_reg || brk_reg)
                begin
                    open_reg       <= 1'b1;
                    cur_tag_reg    <= tag_in_reg;
                    cur_offset_reg <= off_in_reg;
                    cur_start_reg  <= start_in_reg;
                    cur_samp_reg   <= 40'(samp_in_reg);
                end
                else
                    cur_samp_reg <= samp_sum[40] ? CNT_MAX : samp_sum[39:0];
            end
        end
    end

    // request latch, work registers, output register
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
                if (in_valid)
                begin
                    act_reg      <= action;
                    idv_reg      <= id_valid;
                    tag_in_reg   <= source_tag;
                    start_in_reg <= start_ns;
                    rate_in_reg  <= rate_fixed;
                    samp_in_reg  <= record_samples;
                    off_in_reg   <= record_offset & OFF_MASK;
                    bytes_in_reg <= record_bytes;
                end
            ST_DECIDE:
            begin
                brk_reg      <= tag_chg || rate_chg || gap;
                gap_reg      <= gap && !is_flush;
                kind_reg     <= is_flush ? act_reg : KIND_BREAK;
                zero_res_reg <= (act_reg == ACT_END) && !open_reg;
                tsel_reg     <= 1'b0;
            end
            ST_TA_GO:
                neg_reg <= tneg;
            ST_TA_WAIT:
                if (mul_done)
                    a_reg <= mul_p;
            ST_TCMP:
            begin
                if (tear)
                    brk_reg <= 1'b1;
                tsel_reg <= 1'b1;
            end
            ST_E_START:
                end_reg <= cur_start_reg;
            ST_E_SAT:
                end_reg <= end_sat;
            ST_OUT:
                if (slot_free)
                begin
                    if (zero_res_reg)
                    begin
                        entry_kind    <= KIND_EMPTY;
                        offset_gap    <= 1'b0;
                        seg_tag       <= '0;
                        seg_offset    <= '0;
                        seg_bytes     <= '0;
                        seg_start_ns  <= '0;
                        seg_end_ns    <= '0;
                        tail_start_ns <= '0;
                        seg_rate      <= '0;
                        seg_samples   <= '0;
                    end
                    else
                    begin
                        entry_kind    <= kind_reg;
                        offset_gap    <= gap_reg;
                        seg_tag       <= cur_tag_reg;
                        seg_offset    <= cur_offset_reg;
                        seg_bytes     <= (prev_end_reg - cur_offset_reg) & OFF_MASK;
                        seg_start_ns  <= cur_start_reg;
                        seg_end_ns    <= end_reg;
                        tail_start_ns <= prev_start_reg;
                        seg_rate      <= prev_rate_reg;
                        seg_samples   <= cur_samp_reg;
                    end
                end
            default:
                kind_reg <= kind_reg;
        endcase
    end

    assign out_valid = out_valid_reg;

    spsi_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_go),
        .x     (mul_x),
        .y     (mul_y),
        .done  (mul_done),
        .p     (mul_p)
    );

    spsi_div #(
        .NUM_W (NUM_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_go),
        .num   ({mul_p[NSP_W-1:0], {RATE_FRAC_BITS{1'b0}}}),
        .den   (prev_rate_reg),
        .done  (div_done),
        .q     (div_q)
    );

endmodule
`default_nettype wire

@@ bench/segment_index_checker.sv @@
// Checker for the seismic packet segment indexer: watches the request and
// index entry channels, predicts entries and compares. Depends on spsi_pkg.
`timescale 1ns / 100ps
module segment_index_checker
    import spsi_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready,
    input  wire logic        cfg_data,
    input  wire logic        in_valid,
    input  wire logic        in_stall,
    input  wire logic [1:0]  action,
    input  wire logic        id_valid,
    input  wire logic [63:0] source_tag,
    input  wire logic [63:0] start_ns,
    input  wire logic [47:0] rate_fixed,
    input  wire logic [30:0] record_samples,
    input  wire logic [47:0] record_offset,
    input  wire logic [23:0] record_bytes,
    input  wire logic        out_valid,
    input  wire logic        out_stall,
    input  wire logic [1:0]  entry_kind,
    input  wire logic        offset_gap,
    input  wire logic [63:0] seg_tag,
    input  wire logic [47:0] seg_offset,
    input  wire logic [47:0] seg_bytes,
    input  wire logic [63:0] seg_start_ns,
    input  wire logic [63:0] seg_end_ns,
    input  wire logic [63:0] tail_start_ns,
    input  wire logic [47:0] seg_rate,
    input  wire logic [39:0] seg_samples,
    input  wire logic        drain,
    output int               fail_count,
    output int               entries_pending
);

    localparam int FRAC = DEF_RATE_FRAC_BITS;

    typedef struct packed {
        logic [1:0]  kind;
        logic        gap;
        logic [63:0] tag;
        logic [47:0] offs;
        logic [47:0] nbytes;
        logic [63:0] t0;
        logic [63:0] t1;
        logic [63:0] tail;
        logic [47:0] rate;
        logic [39:0] cnt;
    } seg_entry_t;

    seg_entry_t entry_q[$];

    logic        tears_on;
    logic        seg_open;
    logic [63:0] s_tag, s_start, s_prev_start;
    logic [47:0] s_offset, s_prev_end, s_rate;
    logic [30:0] s_prev_cnt;
    logic [39:0] s_cnt;

    function automatic logic is_tear(logic [63:0] t, logic [63:0] ref_t,
                                     logic [47:0] rate, logic [39:0] n);
        logic signed [64:0]  d;
        logic [64:0]         mag;
        logic [127:0]        a, b, e, lim;
        d   = $signed({t[63], t}) - $signed({ref_t[63], ref_t});
        mag = d[64] ? -d : d;
        a   = {63'd0, mag} * {80'd0, rate};
        b   = ({88'd0, n} * 128'd1000000000) << FRAC;
        lim = 128'd1000000000 << (FRAC - 1);
        if (d[64]) e = a + b;
        else if (a >= b) e = a - b;
        else e = b - a;
        return e > lim;
    endfunction

    function automatic logic [63:0] seg_end_time();
        logic [127:0]        num, q;
        logic signed [129:0] sum;
        if (s_rate == 0) return s_start;
        num = ({88'd0, (s_cnt == 0) ? 40'd1 : s_cnt - 40'd1} * 128'd1000000000)
              << FRAC;
        q   = num / {80'd0, s_rate};
        if (s_cnt == 0) sum = $signed({{66{s_start[63]}}, s_start}) - $signed({2'b0, q});
        else sum = $signed({{66{s_start[63]}}, s_start}) + $signed({2'b0, q});
        if (sum > $signed({66'd0, MAXPOS})) return MAXPOS;
        if (sum < -$signed({66'd0, SIGN64})) return SIGN64;
        return sum[63:0];
    endfunction

    function automatic seg_entry_t close_entry(logic [1:0] kind, logic gap);
        seg_entry_t e;
        e.kind   = kind;
        e.gap    = gap;
        e.tag    = s_tag;
        e.offs   = s_offset;
        e.nbytes = s_prev_end - s_offset;
        e.t0     = s_start;
        e.t1     = seg_end_time();
        e.tail   = s_prev_start;
        e.rate   = s_rate;
        e.cnt    = s_cnt;
        return e;
    endfunction

    task automatic clear_segment();
        seg_open = 0; s_tag = 0; s_offset = 0; s_prev_end = 0; s_start = 0;
        s_prev_start = 0; s_rate = 0; s_prev_cnt = 0; s_cnt = 0;
    endtask

    task automatic predict_request();
        logic        tag_chg, rate_chg, gap, tr;
        logic [40:0] sum;
        seg_entry_t  e;
        if (action == ACT_END || action == ACT_ERROR) begin
            if (seg_open) entry_q = {entry_q, close_entry(action, 1'b0)};
            else if (action == ACT_END) begin
                e = '0;
                e.kind = KIND_EMPTY;
                entry_q = {entry_q, e};
            end
            clear_segment();
            return;
        end
        if (action != ACT_RECORD || !id_valid) return;
        if (seg_open) begin
            tag_chg  = source_tag != s_tag;
            rate_chg = rate_fixed != s_rate;
            gap      = record_offset != s_prev_end;
            tr = 0;
            if (tears_on && !tag_chg && !rate_chg)
                tr = is_tear(start_ns, s_prev_start, s_rate, {9'd0, s_prev_cnt}) ||
                     is_tear(start_ns, s_start, s_rate, s_cnt);
            if (!(tag_chg || rate_chg || gap || tr)) begin
                sum = {1'b0, s_cnt} + 41'(record_samples);
                s_cnt = sum[40] ? CNT_MAX : sum[39:0];
                s_prev_start = start_ns;
                s_prev_cnt = record_samples;
                s_prev_end = record_offset + 48'(record_bytes);
                return;
            end
            entry_q = {entry_q, close_entry(KIND_BREAK, gap)};
        end
        seg_open = 1;
        s_tag = source_tag; s_offset = record_offset; s_start = start_ns;
        s_prev_start = start_ns; s_rate = rate_fixed; s_prev_cnt = record_samples;
        s_cnt = 40'(record_samples); s_prev_end = record_offset + 48'(record_bytes);
    endtask

    task automatic check_entry();
        seg_entry_t got, want;
        got = '{entry_kind, offset_gap, seg_tag, seg_offset, seg_bytes, seg_start_ns,
                seg_end_ns, tail_start_ns, seg_rate, seg_samples};
        if (entry_q.size() == 0) begin
            $display("%0t: unexpected entry %h", $time, got);
            fail_count++;
            return;
        end
        want = entry_q.pop_front();
        if (got.kind != want.kind) begin
            $display("%0t: entry_kind exp %0d got %0d", $time, want.kind, got.kind);
            fail_count++;
        end
        if (got.gap != want.gap) begin
            $display("%0t: offset_gap exp %0d got %0d", $time, want.gap, got.gap);
            fail_count++;
        end
        if (got.tag != want.tag) begin
            $display("%0t: seg_tag exp %h got %h", $time, want.tag, got.tag);
            fail_count++;
        end
        if (got.offs != want.offs) begin
            $display("%0t: seg_offset exp %h got %h", $time, want.offs, got.offs);
            fail_count++;
        end
        if (got.nbytes != want.nbytes) begin
            $display("%0t: seg_bytes exp %h got %h", $time, want.nbytes, got.nbytes);
            fail_count++;
        end
        if (got.t0 != want.t0) begin
            $display("%0t: seg_start_ns exp %h got %h", $time, want.t0, got.t0);
            fail_count++;
        end
        if (got.t1 != want.t1) begin
            $display("%0t: seg_end_ns exp %h got %h", $time, want.t1, got.t1);
            fail_count++;
        end
        if (got.tail != want.tail) begin
            $display("%0t: tail_start_ns exp %h got %h", $time, want.tail, got.tail);
            fail_count++;
        end
        if (got.rate != want.rate) begin
            $display("%0t: seg_rate exp %h got %h", $time, want.rate, got.rate);
            fail_count++;
        end
        if (got.cnt != want.cnt) begin
            $display("%0t: seg_samples exp %h got %h", $time, want.cnt, got.cnt);
            fail_count++;
        end
    endtask

    initial begin
        fail_count = 0;
        tears_on = 1;
        clear_segment();
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if (cfg_valid && cfg_ready) tears_on = cfg_data;
            if (in_valid && !in_stall) predict_request();
            if (out_valid && !out_stall) check_entry();
        end
        if (drain) begin
            if (entry_q.size() != 0) begin
                $display("%0t: %0d entries never arrived", $time, entry_q.size());
                fail_count += entry_q.size();
                entry_q.delete();
            end
        end
        entries_pending = entry_q.size();
    end

endmodule

@@ bench/tb_seismic_packet_segment_indexer.sv @@
// Top of the segment indexer testbench: clock, reset, request stimulus,
// config writes and verdict. Depends on spsi_pkg and segment_index_checker.
`timescale 1ns / 100ps
module tb_seismic_packet_segment_indexer;
    import spsi_pkg::*;

    localparam int IDLE_LIMIT = 20000;
    localparam int N_RANDOM   = 850;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        cfg_valid = 0, cfg_data = 0;
    wire         cfg_ready;
    logic        in_valid = 0;
    wire         in_stall;
    logic [1:0]  action = 0;
    logic        id_valid = 0;
    logic [63:0] source_tag = 0, start_ns = 0;
    logic [47:0] rate_fixed = 0, record_offset = 0;
    logic [30:0] record_samples = 0;
    logic [23:0] record_bytes = 0;
    wire         out_valid;
    logic        out_stall = 1;
    wire [1:0]   entry_kind;
    wire         offset_gap;
    wire [63:0]  seg_tag, seg_start_ns, seg_end_ns, tail_start_ns;
    wire [47:0]  seg_offset, seg_bytes, seg_rate;
    wire [39:0]  seg_samples;
    logic        drain = 0;
    int          fail_count, entries_pending;
    int          idle_cycles = 0;
    logic        stim_done = 0;

    // next record continuing the stream model
    logic [63:0] nx_tag, nx_time;
    logic [47:0] nx_rate, nx_off;

    always #5 clk = ~clk;

    seismic_packet_segment_indexer dut (.*);

    segment_index_checker chk (.*);

    // receiver stall: random hold per entry, with quiet stretches
    initial begin
        int w;
        @(posedge rst_n);
        forever begin
            w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
            if (w > 0) begin
                out_stall <= 1;
                repeat (w) @(posedge clk);
            end
            out_stall <= 0;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_valid)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // in_valid stays high after the accept so that a request with no idle
    // gap can follow at the same edge; wait_quiet drops it
    task automatic send_request(logic [1:0] act, logic idv, logic [63:0] tag,
                                logic [63:0] t, logic [47:0] rate, logic [30:0] n,
                                logic [47:0] off, logic [23:0] nb);
        int w;
        w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
        if (w > 0) begin
            in_valid <= 0;
            repeat (w) @(posedge clk);
        end
        in_valid <= 1; action <= act; id_valid <= idv; source_tag <= tag;
        start_ns <= t; rate_fixed <= rate; record_samples <= n;
        record_offset <= off; record_bytes <= nb;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic wait_quiet();
        in_valid <= 0;
        @(posedge clk);
        while (in_stall || out_valid || entries_pending != 0) @(posedge clk);
    endtask

    // mostly contiguous record, starting at a small rate, so the tear math is exercised
    task automatic send_stream_record();
        logic [30:0] n;
        logic [23:0] nb;
        logic [63:0] t;
        int pick;
        n  = $urandom_range(0, 500);
        nb = $urandom_range(64, 4096);
        pick = $urandom_range(0, 19);
        t = nx_time;
        if (pick == 0) nx_tag = {$urandom, $urandom};
        else if (pick == 1) nx_rate = {$urandom, $urandom} & 48'h00FF_FFFF_FFFF;
        else if (pick == 2) nx_off = nx_off + $urandom_range(1, 100);
        else if (pick == 3) t = t + $signed($urandom_range(0, 2000000)) - 1000000;
        send_request(ACT_RECORD, ($urandom_range(0, 30) != 0), nx_tag, t, nx_rate,
                     n, nx_off, nb);
        nx_off = nx_off + nb;
        if (nx_rate != 0)
            nx_time = t + (({64'd0, n} * 128'd1000000000) << 16) / nx_rate;
        else
            nx_time = t;
    endtask

    task automatic wait_idle_and_config(logic v);
        wait_quiet();
        repeat (2) @(posedge clk);
        cfg_valid <= 1; cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 0;
    endtask

    initial begin
        repeat (3) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: empty end, error with nothing open, field extremes
        send_request(ACT_END, 1, 0, 0, 0, 0, 0, 0);
        send_request(ACT_ERROR, 1, 0, 0, 0, 0, 0, 0);
        send_request(ACT_RECORD, 1, '1, MAXPOS, '1, '1, '1, '1);
        send_request(ACT_RECORD, 1, '1, MAXPOS, '1, '1, 48'd0, 24'd0);
        send_request(ACT_RESERVED, 1, 0, 0, 0, 0, 0, 0);
        send_request(ACT_RECORD, 0, 1, 2, 3, 4, 5, 6);
        send_request(ACT_RECORD, 1, 0, SIGN64, 48'd0, 31'd0, 48'd0, 24'd100);
        send_request(ACT_RECORD, 1, 0, SIGN64, 48'd0, 31'd5, 48'd100, 24'd100);
        send_request(ACT_END, 1, 0, 0, 0, 0, 0, 0);
        // one-sample-per-second, contiguous then torn
        send_request(ACT_RECORD, 1, 7, 64'd0, 48'h10000, 31'd10, 48'd0, 24'd512);
        send_request(ACT_RECORD, 1, 7, 64'd10000000000, 48'h10000, 31'd10, 48'd512,
                     24'd512);
        send_request(ACT_RECORD, 1, 7, 64'd20600000000, 48'h10000, 31'd10, 48'd1024,
                     24'd512);
        send_request(ACT_RECORD, 1, 7, 64'd20600000000, 48'h10000, 31'd0, 48'd1536,
                     24'd512);
        send_request(ACT_ERROR, 1, 0, 0, 0, 0, 0, 0);
        send_request(ACT_RECORD, 1, 9, SIGN64, 48'd1, 31'd0, 48'd0, 24'd0);
        send_request(ACT_END, 1, 0, 0, 0, 0, 0, 0);

        wait_idle_and_config(0);
        send_request(ACT_RECORD, 1, 7, 64'd0, 48'h10000, 31'd10, 48'd0, 24'd512);
        send_request(ACT_RECORD, 1, 7, 64'd99, 48'h10000, 31'd10, 48'd512, 24'd512);
        send_request(ACT_RECORD, 1, 8, 64'd99, 48'h10000, 31'd10, 48'd1024, 24'd512);
        send_request(ACT_END, 1, 0, 0, 0, 0, 0, 0);

        for (int phase = 0; phase < 4; phase++) begin
            wait_idle_and_config(phase[0]);
            nx_tag = {$urandom, $urandom};
            nx_rate = $urandom_range(1, 200) << 16;
            nx_off = {$urandom, $urandom};
            nx_time = {$urandom, $urandom};
            for (int i = 0; i < N_RANDOM / 4; i++) begin
                int r;
                r = $urandom_range(0, 99);
                if (r < 80) send_stream_record();
                else if (r < 85)
                    send_request(ACT_RECORD, $urandom, {$urandom, $urandom},
                                 {$urandom, $urandom}, {$urandom, $urandom},
                                 $urandom, {$urandom, $urandom}, $urandom);
                else if (r < 92) send_request(ACT_END, $urandom, 0, 0, 0, 0, 0, 0);
                else if (r < 97) send_request(ACT_ERROR, $urandom, 0, 0, 0, 0, 0, 0);
                else send_request(ACT_RESERVED, $urandom, {$urandom, $urandom},
                                  0, 0, 0, 0, 0);
            end
            send_request(ACT_END, 1, 0, 0, 0, 0, 0, 0);
        end

        wait_quiet();
        repeat (400) @(posedge clk);
        drain <= 1;
        @(posedge clk);
        @(posedge clk);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

@@ sim.f @@
sv/spsi_pkg.sv
sv/spsi_mul.sv
sv/spsi_div.sv
sv/seismic_packet_segment_indexer.sv
bench/segment_index_checker.sv
bench/tb_seismic_packet_segment_indexer.sv
